// ----- rtl/lrupm_pkg.sv -----
// shared types and constants for the lru replacer with pin marks
// used by lrupm_front, lrupm_back and the top level; no dependencies
package lrupm_pkg;

    localparam int FRAME_W        = 6;
    localparam int CNT_W          = 7;
    localparam int FRAME_IDS      = 1 << FRAME_W;
    localparam int MAX_FRAMES_DEF = 64;
    localparam int Q_DEPTH        = 2;
    localparam int IN_DATA_W      = 8;
    localparam int IN_USER_W      = 2;
    localparam int OUT_DATA_W     = 16;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_SET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EVICT  = 2'd3
    } t_op;

    localparam logic ST_APPLIED = 1'b0;
    localparam logic ST_IGNORED = 1'b1;

    typedef struct packed {
        t_op                op;
        logic [FRAME_W-1:0] fid;
        logic               ev;
        logic               in_range;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]   evictable_count;
        logic               op_status;
        logic [FRAME_W-1:0] evicted_frame;
        logic               evicted_valid;
    } t_result;

endpackage

// ----- rtl/lrupm_front.sv -----
// front end: accepts stream requests, classifies them and queues them
// depends on lrupm_pkg
module lrupm_front #(
    parameter int MAX_FRAMES = lrupm_pkg::MAX_FRAMES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [5:0] frame number, [6] evictable_value, [7] zero
    input  logic [lrupm_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [1:0] op
    input  logic [lrupm_pkg::IN_USER_W-1:0] s_axis_tuser,
    output logic                           o_cmd_vld,
    output lrupm_pkg::t_cmd                o_cmd,
    input  logic                           i_cmd_pop
);
    import lrupm_pkg::*;

    localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);
    localparam logic [QPW-1:0] Q_LAST = QPW'(Q_DEPTH - 1);
    localparam logic [QCW-1:0] Q_FULL = QCW'(Q_DEPTH);

    t_cmd           r_q [Q_DEPTH];
    logic [QPW-1:0] r_wp, n_wp;
    logic [QPW-1:0] r_rp, n_rp;
    logic [QCW-1:0] r_cnt, n_cnt;
    t_cmd           in_cmd;
    logic           push;
    logic           pop;

    always_comb begin
        in_cmd.op       = t_op'(s_axis_tuser);
        in_cmd.fid      = s_axis_tdata[FRAME_W-1:0];
        in_cmd.ev       = s_axis_tdata[FRAME_W];
        in_cmd.in_range = (32'(s_axis_tdata[FRAME_W-1:0]) < MAX_FRAMES);
    end

    assign s_axis_tready = (r_cnt != Q_FULL);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_cmd_vld     = (r_cnt != '0);
    assign pop           = i_cmd_pop && o_cmd_vld;
    assign o_cmd         = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == Q_LAST) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == Q_LAST) ? '0 : r_rp + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_cmd;
        end
    end

endmodule

// ----- rtl/lrupm_back.sv -----
// back end: recency rank memory, mark and tracked bits, sweep sequencer
// depends on lrupm_pkg
module lrupm_back #(
    parameter int MAX_FRAMES = lrupm_pkg::MAX_FRAMES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [lrupm_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  logic                        i_cmd_vld,
    input  lrupm_pkg::t_cmd             i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_res_vld,
    output lrupm_pkg::t_result          o_res,
    input  logic                        i_res_rdy
);
    import lrupm_pkg::*;

    localparam int SLOTS = (MAX_FRAMES < FRAME_IDS) ? MAX_FRAMES : FRAME_IDS;
    localparam int SW    = $clog2(SLOTS);
    localparam logic [SW-1:0]    LAST    = SW'(SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_BUMP_LT,
        M_BUMP_ALL,
        M_DEC_GT,
        M_SCAN
    } t_mode;

    logic [SW-1:0] r_rank_mem [SLOTS];
    logic [SW-1:0] r_rd_data;
    logic [SW-1:0] mem_ra;
    logic [SW-1:0] mem_wa;
    logic [SW-1:0] mem_wd;
    logic          mem_we;

    t_state           r_state, n_state;
    t_mode            r_mode, n_mode;
    t_op              r_op, n_op;
    logic [SW-1:0]    r_fid, n_fid;
    logic             r_ev, n_ev;
    logic             r_inr, n_inr;
    logic [SW-1:0]    r_limit, n_limit;
    logic [SW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_rd_go, n_rd_go;
    logic             r_wr_vld, n_wr_vld;
    logic [SW-1:0]    r_wr_idx, n_wr_idx;
    logic             r_found, n_found;
    logic [SW-1:0]    r_best, n_best;
    logic [SW-1:0]    r_best_rank, n_best_rank;
    logic [SLOTS-1:0] r_trk, n_trk;
    logic [SLOTS-1:0] r_evb, n_evb;
    logic [CNT_W-1:0] r_trk_cnt, n_trk_cnt;
    logic [CNT_W-1:0] r_ev_cnt, n_ev_cnt;
    logic [CNT_W-1:0] r_cap, n_cap;
    logic             r_victim_vld, n_victim_vld;
    logic             r_status, n_status;
    logic             r_res_vld, n_res_vld;
    t_result          r_res, n_res;

    logic [CNT_W-1:0] cap;
    logic             cur_trk;
    logic             cur_ev;
    logic             w_trk;
    logic             w_ev;
    logic             scan_hit;
    logic             fin_found;
    logic [SW-1:0]    fin_best;
    logic [SW-1:0]    fin_rank;
    logic             sweep_end;

    assign cap       = (r_cap > SLOTS_C) ? SLOTS_C : r_cap;
    assign cur_trk   = r_inr && r_trk[r_fid];
    assign cur_ev    = r_evb[r_fid];
    assign w_trk     = r_trk[r_wr_idx];
    assign w_ev      = r_evb[r_wr_idx];
    assign scan_hit  = w_trk && w_ev && (!r_found || (r_rd_data > r_best_rank));
    assign fin_found = r_found || scan_hit;
    assign fin_best  = scan_hit ? r_wr_idx : r_best;
    assign fin_rank  = scan_hit ? r_rd_data : r_best_rank;
    assign sweep_end = r_wr_vld && (r_wr_idx == LAST);

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_op         = r_op;
        n_fid        = r_fid;
        n_ev         = r_ev;
        n_inr        = r_inr;
        n_limit      = r_limit;
        n_rd_idx     = r_rd_idx;
        n_rd_go      = r_rd_go;
        n_wr_vld     = r_wr_vld;
        n_wr_idx     = r_wr_idx;
        n_found      = r_found;
        n_best       = r_best;
        n_best_rank  = r_best_rank;
        n_trk        = r_trk;
        n_evb        = r_evb;
        n_trk_cnt    = r_trk_cnt;
        n_ev_cnt     = r_ev_cnt;
        n_cap        = r_cap;
        n_victim_vld = r_victim_vld;
        n_status     = r_status;
        n_res_vld    = r_res_vld;
        n_res        = r_res;
        o_cmd_pop    = 1'b0;
        mem_ra       = r_rd_idx;
        mem_wa       = r_wr_idx;
        mem_wd       = r_rd_data;
        mem_we       = 1'b0;

        if (i_cfg_wr_en) begin
            n_cap = i_cfg_wr_data;
        end
        if (r_res_vld && i_res_rdy) begin
            n_res_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                n_victim_vld = 1'b0;
                n_status     = ST_IGNORED;
                if (i_cmd_vld) begin
                    o_cmd_pop = 1'b1;
                    n_op      = i_cmd.op;
                    n_fid     = i_cmd.fid[SW-1:0];
                    n_ev      = i_cmd.ev;
                    n_inr     = i_cmd.in_range;
                    mem_ra    = i_cmd.fid[SW-1:0];
                    n_state   = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state  = S_DONE;
                n_limit  = r_rd_data;
                n_rd_idx = '0;
                n_wr_vld = 1'b0;
                n_found  = 1'b0;
                case (r_op)
                    OP_ACCESS: begin
                        if (cur_trk) begin
                            n_mode   = M_BUMP_LT;
                            n_status = ST_APPLIED;
                            n_rd_go  = 1'b1;
                            n_state  = S_SWEEP;
                        end else if (r_inr && (r_trk_cnt < cap)) begin
                            n_mode       = M_BUMP_ALL;
                            n_trk[r_fid] = 1'b1;
                            n_evb[r_fid] = 1'b1;
                            n_trk_cnt    = r_trk_cnt + 1'b1;
                            n_ev_cnt     = r_ev_cnt + 1'b1;
                            n_status     = ST_APPLIED;
                            n_rd_go      = 1'b1;
                            n_state      = S_SWEEP;
                        end
                    end
                    OP_SET: begin
                        if (cur_trk) begin
                            n_evb[r_fid] = r_ev;
                            n_status     = ST_APPLIED;
                            if (cur_ev != r_ev) begin
                                n_ev_cnt = r_ev ? r_ev_cnt + 1'b1 : r_ev_cnt - 1'b1;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (cur_trk && cur_ev) begin
                            n_mode       = M_DEC_GT;
                            n_trk[r_fid] = 1'b0;
                            n_evb[r_fid] = 1'b0;
                            n_trk_cnt    = r_trk_cnt - 1'b1;
                            n_ev_cnt     = r_ev_cnt - 1'b1;
                            n_status     = ST_APPLIED;
                            n_rd_go      = 1'b1;
                            n_state      = S_SWEEP;
                        end
                    end
                    default: begin
                        n_mode  = M_SCAN;
                        n_rd_go = 1'b1;
                        n_state = S_SWEEP;
                    end
                endcase
            end
            S_SWEEP: begin
                // read stage
                n_wr_vld = r_rd_go;
                n_wr_idx = r_rd_idx;
                if (r_rd_go) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                    if (r_rd_idx == LAST) begin
                        n_rd_go = 1'b0;
                    end
                end
                // update stage
                if (r_wr_vld) begin
                    case (r_mode)
                        M_BUMP_LT: begin
                            if (r_wr_idx == r_fid) begin
                                mem_we = 1'b1;
                                mem_wd = '0;
                            end else if (w_trk && (r_rd_data < r_limit)) begin
                                mem_we = 1'b1;
                                mem_wd = r_rd_data + 1'b1;
                            end
                        end
                        M_BUMP_ALL: begin
                            if (r_wr_idx == r_fid) begin
                                mem_we = 1'b1;
                                mem_wd = '0;
                            end else if (w_trk) begin
                                mem_we = 1'b1;
                                mem_wd = r_rd_data + 1'b1;
                            end
                        end
                        M_DEC_GT: begin
                            if (w_trk && (r_rd_data > r_limit)) begin
                                mem_we = 1'b1;
                                mem_wd = r_rd_data - 1'b1;
                            end
                        end
                        default: begin
                            n_found     = fin_found;
                            n_best      = fin_best;
                            n_best_rank = fin_rank;
                        end
                    endcase
                end
                if (sweep_end) begin
                    n_state = S_DONE;
                    if ((r_mode == M_SCAN) && fin_found) begin
                        // drop the victim, then close the rank gap
                        n_trk[fin_best] = 1'b0;
                        n_evb[fin_best] = 1'b0;
                        n_trk_cnt       = r_trk_cnt - 1'b1;
                        n_ev_cnt        = r_ev_cnt - 1'b1;
                        n_limit         = fin_rank;
                        n_mode          = M_DEC_GT;
                        n_victim_vld    = 1'b1;
                        n_status        = ST_APPLIED;
                        n_rd_idx        = '0;
                        n_rd_go         = 1'b1;
                        n_wr_vld        = 1'b0;
                        n_state         = S_SWEEP;
                    end
                end
            end
            S_DONE: begin
                if (!r_res_vld || i_res_rdy) begin
                    n_res.evicted_valid   = r_victim_vld;
                    n_res.evicted_frame   = r_victim_vld ? FRAME_W'(r_best) : '0;
                    n_res.op_status       = r_status;
                    n_res.evictable_count = r_ev_cnt;
                    n_res_vld             = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= M_SCAN;
            r_rd_go      <= 1'b0;
            r_wr_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_trk        <= '0;
            r_evb        <= '0;
            r_trk_cnt    <= '0;
            r_ev_cnt     <= '0;
            r_cap        <= CAP_RESET;
            r_victim_vld <= 1'b0;
            r_status     <= ST_IGNORED;
            r_res_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_rd_go      <= n_rd_go;
            r_wr_vld     <= n_wr_vld;
            r_found      <= n_found;
            r_trk        <= n_trk;
            r_evb        <= n_evb;
            r_trk_cnt    <= n_trk_cnt;
            r_ev_cnt     <= n_ev_cnt;
            r_cap        <= n_cap;
            r_victim_vld <= n_victim_vld;
            r_status     <= n_status;
            r_res_vld    <= n_res_vld;
        end
        r_op        <= n_op;
        r_fid       <= n_fid;
        r_ev        <= n_ev;
        r_inr       <= n_inr;
        r_limit     <= n_limit;
        r_rd_idx    <= n_rd_idx;
        r_wr_idx    <= n_wr_idx;
        r_best      <= n_best;
        r_best_rank <= n_best_rank;
        r_res       <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_rank_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_rank_mem[mem_ra];
    end

    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

`ifndef ASSERT_OFF
    a_ev_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_evb & ~r_trk) == '0)
        else $error("evictable mark on untracked slot");

    a_trk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_trk) == 32'(r_trk_cnt))
        else $error("tracked count out of step with tracked bits");

    a_ev_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_evb) == 32'(r_ev_cnt))
        else $error("evictable count out of step with marks");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SWEEP) |-> !mem_we)
        else $error("rank write outside a sweep");

    a_done_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_cmd_vld) |=> (r_state == S_LOOK))
        else $error("popped request not looked up");
`endif

endmodule

// ----- rtl/lru_replacer_with_pin_marks_core.sv -----
// top level of the lru replacer with pin marks
// depends on lrupm_pkg, lrupm_front, lrupm_back
//
// Each request passes through a pop step, a lookup in the rank memory,
// a result step and, where the order changes, a sweep over all slots
// (min(MAX_FRAMES, 64) of them) through the rank memory, which has one
// read and one write port and sweeps one slot per cycle. Set-evictable
// requests and ignored access or remove requests skip the sweep; access
// and remove take one sweep, evict one sweep when nothing is evictable and
// two otherwise (a scan for the oldest evictable frame, then the rank
// fix-up); the result register and a two-entry request queue let the next
// request be taken while a result waits. No clearing pass after reset.
module lru_replacer_with_pin_marks_core #(
    parameter int MAX_FRAMES = lrupm_pkg::MAX_FRAMES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    // frame_capacity
    input  logic [lrupm_pkg::CNT_W-1:0]      i_cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [5:0] frame number, [6] evictable_value, [7] zero
    input  logic [lrupm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] op
    input  logic [lrupm_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] evicted_valid, [6:1] evicted_frame, [7] op_status,
    // [14:8] evictable_count, [15] zero
    output logic [lrupm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import lrupm_pkg::*;

    logic    cmd_vld;
    t_cmd    cmd;
    logic    cmd_pop;
    t_result res;

    lrupm_front #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_vld     (cmd_vld),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    lrupm_back #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_vld     (cmd_vld),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_res_vld     (m_axis_tvalid),
        .o_res         (res),
        .i_res_rdy     (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, res.evictable_count, res.op_status,
                           res.evicted_frame, res.evicted_valid};

endmodule

// ----- test/tb.sv -----
// self-checking testbench for lru_replacer_with_pin_marks_core
// predicts each result from its own copy of the recency order, then checks the stream
// depends on lrupm_pkg and lru_replacer_with_pin_marks_core
module tb;
    import lrupm_pkg::*;

    localparam int N_FRAMES    = MAX_FRAMES_DEF;
    localparam int SETTLE      = 2 * N_FRAMES + 16;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        t_op                op;
        logic [FRAME_W-1:0] fid;
        logic               ev;
    } t_frame_req;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]      i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_frame_req pending_reqs[$];
    t_result    expected_results[$];
    t_frame_req cur_req;

    // predictor state
    bit lru_tracked[N_FRAMES];
    bit lru_evictable[N_FRAMES];
    int lru_rank[N_FRAMES];
    int lru_tracked_cnt  = 0;
    int lru_evictable_cnt = 0;
    int lru_capacity     = int'(CAP_RESET);

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit quiet          = 1'b0;
    int mismatches     = 0;
    int cycle_cnt      = 0;

    lru_replacer_with_pin_marks_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void drop_frame(int s);
        for (int i = 0; i < N_FRAMES; i++) begin
            if (lru_tracked[i] && lru_rank[i] > lru_rank[s])
                lru_rank[i]--;
        end
        if (lru_evictable[s])
            lru_evictable_cnt--;
        lru_tracked[s]   = 1'b0;
        lru_evictable[s] = 1'b0;
        lru_rank[s]      = 0;
        lru_tracked_cnt--;
    endfunction

    function automatic t_result predict_replacer(t_frame_req r);
        t_result res;
        int      cap;
        int      old_rank;
        int      best;
        bit      found;
        res           = '0;
        res.op_status = ST_IGNORED;
        cap           = (lru_capacity > N_FRAMES) ? N_FRAMES : lru_capacity;
        best          = 0;
        found         = 1'b0;
        case (r.op)
            OP_ACCESS: begin
                if (lru_tracked[r.fid]) begin
                    old_rank = lru_rank[r.fid];
                    for (int i = 0; i < N_FRAMES; i++)
                        if (lru_tracked[i] && lru_rank[i] < old_rank)
                            lru_rank[i]++;
                    lru_rank[r.fid] = 0;
                    res.op_status   = ST_APPLIED;
                end else if (lru_tracked_cnt < cap) begin
                    for (int i = 0; i < N_FRAMES; i++)
                        if (lru_tracked[i])
                            lru_rank[i]++;
                    lru_tracked[r.fid]   = 1'b1;
                    lru_evictable[r.fid] = 1'b1;
                    lru_rank[r.fid]      = 0;
                    lru_tracked_cnt++;
                    lru_evictable_cnt++;
                    res.op_status = ST_APPLIED;
                end
            end
            OP_SET: begin
                if (lru_tracked[r.fid]) begin
                    if (lru_evictable[r.fid] != r.ev) begin
                        lru_evictable[r.fid] = r.ev;
                        if (r.ev)
                            lru_evictable_cnt++;
                        else
                            lru_evictable_cnt--;
                    end
                    res.op_status = ST_APPLIED;
                end
            end
            OP_REMOVE: begin
                if (lru_tracked[r.fid] && lru_evictable[r.fid]) begin
                    drop_frame(r.fid);
                    res.op_status = ST_APPLIED;
                end
            end
            default: begin
                for (int i = 0; i < N_FRAMES; i++) begin
                    if (lru_tracked[i] && lru_evictable[i] &&
                        (!found || lru_rank[i] > lru_rank[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    drop_frame(best);
                    res.evicted_valid = 1'b1;
                    res.evicted_frame = FRAME_W'(best);
                    res.op_status     = ST_APPLIED;
                end
            end
        endcase
        res.evictable_count = CNT_W'(lru_evictable_cnt);
        return res;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_frame_req nxt;
        bit         hold;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_replacer(cur_req));
            hold = s_axis_tvalid && !s_axis_tready;
            if (!hold) begin
                if (pending_reqs.size() > 0 &&
                    (quiet || $urandom_range(0, 99) >= send_idle_pct)) begin
                    nxt           = pending_reqs.pop_front();
                    cur_req       <= nxt;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, nxt.ev, nxt.fid};
                    s_axis_tuser  <= nxt.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[OUT_DATA_W-2:0]);
            if (expected_results.size() == 0) begin
                $error("unexpected result: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got.evicted_valid !== want.evicted_valid) begin
                    $error("evicted_valid: expected %0d, got %0d",
                           want.evicted_valid, got.evicted_valid);
                    mismatches++;
                end
                if (got.evicted_frame !== want.evicted_frame) begin
                    $error("evicted_frame: expected %0d, got %0d",
                           want.evicted_frame, got.evicted_frame);
                    mismatches++;
                end
                if (got.op_status !== want.op_status) begin
                    $error("op_status: expected %0d, got %0d",
                           want.op_status, got.op_status);
                    mismatches++;
                end
                if (got.evictable_count !== want.evictable_count) begin
                    $error("evictable_count: expected %0d, got %0d",
                           want.evictable_count, got.evictable_count);
                    mismatches++;
                end
            end
        end
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // stretches without idling on either side
    always @(posedge i_clk) begin
        if (quiet ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 95) == 0))
            quiet <= !quiet;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_req(t_op op, int fid, bit ev);
        t_frame_req r;
        r.op  = op;
        r.fid = FRAME_W'(fid);
        r.ev  = ev;
        pending_reqs.push_back(r);
    endtask

    task automatic add_random_reqs(int n, int hot_base);
        int   k;
        int   fid;
        t_op  op;
        repeat (n) begin
            k   = $urandom_range(0, 99);
            op  = (k < 45) ? OP_ACCESS : (k < 65) ? OP_SET : (k < 75) ? OP_REMOVE : OP_EVICT;
            fid = ($urandom_range(0, 9) < 7) ? (hot_base + $urandom_range(0, 11)) % N_FRAMES
                                             : $urandom_range(0, N_FRAMES - 1);
            add_req(op, fid, $urandom_range(0, 9) < 6);
        end
    endtask

    // sampled at the falling edge, once driver and monitor updates have settled
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_capacity(int value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CNT_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        lru_capacity  = value;
    endtask

    initial begin
        int start;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, pins, hits and evict order at reset capacity
        add_req(OP_EVICT,  0,  1'b0);
        add_req(OP_SET,    63, 1'b1);
        add_req(OP_REMOVE, 0,  1'b1);
        add_req(OP_ACCESS, 0,  1'b0);
        add_req(OP_ACCESS, 63, 1'b1);
        add_req(OP_ACCESS, 42, 1'b0);
        add_req(OP_ACCESS, 0,  1'b1);
        add_req(OP_SET,    63, 1'b0);
        add_req(OP_SET,    63, 1'b0);
        add_req(OP_REMOVE, 63, 1'b1);
        add_req(OP_EVICT,  21, 1'b1);
        add_req(OP_SET,    63, 1'b1);
        add_req(OP_REMOVE, 63, 1'b0);
        add_req(OP_EVICT,  63, 1'b0);
        add_req(OP_EVICT,  0,  1'b1);
        wait_idle();

        // zero capacity refuses a new access
        write_capacity(0);
        add_req(OP_ACCESS, 5, 1'b0);
        wait_idle();

        // single slot
        write_capacity(1);
        add_req(OP_ACCESS, 5, 1'b0);
        add_req(OP_ACCESS, 6, 1'b0);
        add_req(OP_SET,    5, 1'b0);
        add_req(OP_EVICT,  0, 1'b0);
        add_req(OP_SET,    5, 1'b1);
        add_req(OP_EVICT,  0, 1'b0);
        wait_idle();

        // capacity lowered below the tracked count
        write_capacity(64);
        add_req(OP_ACCESS, 1, 1'b0);
        add_req(OP_ACCESS, 2, 1'b0);
        add_req(OP_ACCESS, 3, 1'b0);
        wait_idle();
        write_capacity(2);
        add_req(OP_ACCESS, 4, 1'b0);
        add_req(OP_REMOVE, 3, 1'b0);
        add_req(OP_REMOVE, 2, 1'b0);
        add_req(OP_ACCESS, 4, 1'b0);
        wait_idle();

        // full table, no idling
        write_capacity(64);
        start = $urandom_range(0, N_FRAMES - 1);
        for (int i = 0; i < N_FRAMES; i++) begin
            add_req(OP_ACCESS, (start + i) % N_FRAMES, 1'b0);
            if ($urandom_range(0, 4) == 0)
                add_req(OP_SET, (start + i) % N_FRAMES, 1'b0);
        end
        add_random_reqs(70, $urandom_range(0, N_FRAMES - 1));
        wait_idle();

        // sender idle
        write_capacity(3);
        send_idle_pct = 73;
        add_random_reqs(125, $urandom_range(0, N_FRAMES - 1));
        wait_idle();

        // receiver stalling, capacity above the frame count
        write_capacity(127);
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        add_random_reqs(125, $urandom_range(0, N_FRAMES - 1));
        wait_idle();

        // both sides
        write_capacity($urandom_range(1, 20));
        send_idle_pct  = 34;
        recv_stall_pct = 34;
        add_random_reqs(125, $urandom_range(0, N_FRAMES - 1));
        wait_idle();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/lrupm_pkg.sv
rtl/lrupm_front.sv
rtl/lrupm_back.sv
rtl/lru_replacer_with_pin_marks_core.sv
test/tb.sv
